// File: rtl/brsd_pkg.sv
// Types and constants shared by the blitter run-length span decoder.
package brsd_pkg;

  localparam int unsigned MaxBitmaps = 8;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);

  localparam logic [9:0]  CursorMax  = 10'd1023;
  localparam logic [10:0] SideLimit  = 11'd256;
  localparam logic [8:0]  SideLen    = 9'd256;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STREAM = 2'd1,
    CMD_LAYER  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DRAW    = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_LAYER  = 2'd1,
    PH_COLUMN = 2'd2,
    PH_COUNT  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_DEST_X  = 2'd0,
    REG_DEST_Y  = 2'd1,
    REG_PRESENT = 2'd2
  } reg_e;

  localparam logic [3:0] OpStop    = 4'h0;
  localparam logic [3:0] OpShortHi = 4'hb;
  localparam logic [3:0] OpCount   = 4'hc;
  localparam logic [3:0] OpMove    = 4'hd;
  localparam logic [3:0] OpLayer   = 4'he;
  localparam logic [3:0] OpLine    = 4'hf;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  span_x;
    logic [7:0]  span_y;
    logic [8:0]  span_len;
    logic [3:0]  pen;
    logic [7:0]  write_enable;
    logic [15:0] fill_start;
    logic        last;
  } res_t;

endpackage

// File: rtl/blitter_rle_span_decoder.sv
// Blitter run-length span decoder: stream bytes in, span and fill words out.
//
// Input channel (s_axis): one word per cycle while ready. tuser carries the command
// (start run, stream byte, set layer mask, clear with pen), tdata the byte, tlast marks
// the last byte held in source memory. Output channel (m_axis): tuser is the result kind
// (draw span, fill to bitmap end, run stopped, source overrun), tlast marks the last
// result caused by one input word, tdata packs the span and fill fields.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 dest_x,
// 1 dest_y, 2 present_bitmaps); write only while both channels are idle.
// The results of a word accepted at one edge can be offered from the next cycle on.
// Throughput: one input word per cycle while s_axis_tready is high; the decode is a
// single combinational pass into a 4-entry result queue. A word causing two results
// (span plus overrun) pushes two queue entries, and s_axis_tready drops while fewer than
// two queue entries are free, so a stalled receiver back-pressures the input.
// Reset: run idle, cursor at 0, layer mask clear, dest_x/dest_y 0, present_bitmaps 8,
// result queue empty.
module blitter_rle_span_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [1:0]  s_axis_tuser,   // command
  input  logic        s_axis_tlast,   // source_end
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // span_x, span_y, span_len, pen, write_enable,
                                      // fill_start, zero pad
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import brsd_pkg::*;

  logic [7:0]  dest_x_q, dest_y_q;
  logic [3:0]  present_q;
  logic        running_q, running_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  lpen_q, lpen_d;
  logic [9:0]  cx_q, cx_d;
  logic [9:0]  cy_q, cy_d;
  logic [7:0]  lmask_q, lmask_d;

  res_t              fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   cnt_q, cnt_d;

  logic        accept, pop;
  cmd_e        cmd;
  logic [7:0]  enables;
  logic [3:0]  n_bm;
  logic        draw_go;
  logic [7:0]  draw_cnt;
  logic [3:0]  draw_pen;
  logic [10:0] draw_end;
  logic        v0, v1;
  res_t        r0, r1;
  logic [1:0]  n_push;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  // write enables: inverted layer mask within the fitted bitmaps
  always_comb begin
    n_bm = (present_q > 4'(MaxBitmaps)) ? 4'(MaxBitmaps) : present_q;
    for (int i = 0; i < 8; i++) begin
      enables[i] = !lmask_q[i] && (4'(i) < n_bm);
    end
  end

  assign draw_end = {1'b0, cx_q} + {3'b000, draw_cnt};

  always_comb begin
    running_d = running_q;
    phase_d   = phase_q;
    lpen_d    = lpen_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    lmask_d   = lmask_q;
    draw_go   = 1'b0;
    draw_cnt  = s_axis_tdata;
    draw_pen  = lpen_q;
    v0        = 1'b0;
    v1        = 1'b0;
    r0        = '0;
    r1        = '0;
    r1.kind   = KIND_OVERRUN;
    r1.last   = 1'b1;

    unique case (cmd)
      CMD_START: begin
        running_d = 1'b1;
        phase_d   = PH_OPCODE;
        cx_d      = {2'b00, dest_x_q};
        cy_d      = {2'b00, dest_y_q};
      end
      CMD_LAYER: lmask_d = s_axis_tdata;
      CMD_CLEAR: begin
        v0              = 1'b1;
        r0.kind         = KIND_FILL;
        r0.span_x       = dest_x_q;
        r0.span_y       = dest_y_q;
        r0.pen          = s_axis_tdata[7:4];
        r0.write_enable = enables;
        r0.fill_start   = {dest_y_q, dest_x_q};
        r0.last         = 1'b1;
      end
      CMD_STREAM: begin
        if (running_q) begin
          unique case (phase_q)
            PH_OPCODE: begin
              if (s_axis_tdata[3:0] == OpStop) begin
                running_d = 1'b0;
                v0        = 1'b1;
                r0.kind   = KIND_STOP;
                r0.last   = 1'b1;
              end else if (s_axis_tdata[3:0] <= OpShortHi) begin
                draw_go  = 1'b1;
                draw_cnt = {4'h0, s_axis_tdata[3:0]};
                draw_pen = s_axis_tdata[7:4];
              end else if (s_axis_tdata[3:0] == OpCount) begin
                lpen_d  = s_axis_tdata[7:4];
                phase_d = PH_COUNT;
              end else if (s_axis_tdata[3:0] == OpMove) begin
                lpen_d  = s_axis_tdata[7:4];
                phase_d = PH_COLUMN;
              end else if (s_axis_tdata[3:0] == OpLayer) begin
                cx_d    = {2'b00, dest_x_q};
                phase_d = PH_LAYER;
              end else begin
                // next line
                cy_d = (cy_q == CursorMax) ? CursorMax : cy_q + 10'd1;
                cx_d = {2'b00, dest_x_q};
              end
            end
            PH_LAYER: begin
              lmask_d = s_axis_tdata;
              phase_d = PH_OPCODE;
            end
            PH_COLUMN: begin
              cx_d    = {2'b00, dest_x_q} + {2'b00, s_axis_tdata};
              phase_d = PH_COUNT;
            end
            PH_COUNT: begin
              phase_d = PH_OPCODE;
              draw_go = 1'b1;
            end
            default: phase_d = PH_OPCODE;
          endcase

          if (draw_go) begin
            cx_d = draw_end[10] ? CursorMax : draw_end[9:0];
            if (draw_cnt != 8'd0 && cx_q[9:8] == 2'b00 && cy_q[9:8] == 2'b00) begin
              v0              = 1'b1;
              r0.kind         = KIND_DRAW;
              r0.span_x       = cx_q[7:0];
              r0.span_y       = cy_q[7:0];
              r0.span_len     = (draw_end >= SideLimit) ? SideLen - {1'b0, cx_q[7:0]}
                                                        : draw_end[8:0] - {1'b0, cx_q[7:0]};
              r0.pen          = draw_pen;
              r0.write_enable = enables;
              r0.last         = !s_axis_tlast;
            end
          end

          // a stop word ends the run before the source end check
          if (s_axis_tlast && !(phase_q == PH_OPCODE && s_axis_tdata[3:0] == OpStop)) begin
            running_d = 1'b0;
            phase_d   = PH_OPCODE;
            v1        = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // result queue: up to two words pushed, one popped per cycle while m_axis_tready is high
  assign n_push        = accept ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
  assign s_axis_tready = (cnt_q <= (FifoAw + 1)'(FifoDepth - 2));
  assign m_axis_tvalid = (cnt_q != '0);
  assign cnt_d         = cnt_q + {{(FifoAw - 1){1'b0}}, n_push} - {{FifoAw{1'b0}}, pop};

  always_ff @(posedge clk_i) begin
    if (accept && (v0 || v1)) begin
      fifo_q[wr_ptr_q] <= v0 ? r0 : r1;
    end
    if (accept && v0 && v1) begin
      fifo_q[wr_ptr_q + FifoAw'(1)] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q  <= '0;
      dest_y_q  <= '0;
      present_q <= 4'd8;
      running_q <= 1'b0;
      phase_q   <= PH_OPCODE;
      lpen_q    <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      lmask_q   <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DEST_X:  dest_x_q  <= cfg_data_i;
          REG_DEST_Y:  dest_y_q  <= cfg_data_i;
          REG_PRESENT: present_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        running_q <= running_d;
        phase_q   <= phase_d;
        lpen_q    <= lpen_d;
        cx_q      <= cx_d;
        cy_q      <= cy_d;
        lmask_q   <= lmask_d;
      end
      wr_ptr_q <= wr_ptr_q + FifoAw'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  res_t head;
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {3'b000, head.fill_start, head.write_enable, head.pen,
                          head.span_len, head.span_y, head.span_x};

endmodule

// File: test/blitter_rle_span_decoder_test.sv
// Self-checking testbench for the blitter run-length span decoder: directed and random byte streams.
module blitter_rle_span_decoder_test;
  import brsd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic [1:0]  s_axis_tuser;   // command
  logic        s_axis_tlast;   // source_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // span_x, span_y, span_len, pen, write_enable, fill_start, pad
  logic [1:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;   // last
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;

  blitter_rle_span_decoder i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // decoder state as predicted
  logic        run_active;
  phase_e      phase;
  logic [3:0]  pen_hold;
  logic [9:0]  cur_x;
  logic [9:0]  cur_y;
  logic [7:0]  layer_mask;
  logic [7:0]  cfg_dest_x;
  logic [7:0]  cfg_dest_y;
  logic [3:0]  cfg_present;

  res_t expected_spans[$];
  res_t step_results[$];

  int error_count;
  int words_sent;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, want %0h", field, got, want);
    error_count++;
  endtask

  task automatic check_field(string field, longint got, longint want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  function automatic logic [7:0] layer_enables();
    int n;
    n = (cfg_present > MaxBitmaps) ? MaxBitmaps : cfg_present;
    return 8'(((1 << n) - 1) & ~{24'd0, layer_mask});
  endfunction

  function automatic void plot_span(int count, logic [3:0] pen);
    int   end_x;
    res_t r;
    end_x = int'(cur_x) + count;
    if (count > 0 && cur_x < SideLimit && cur_y < SideLimit) begin
      r = '0;
      r.kind         = KIND_DRAW;
      r.span_x       = cur_x[7:0];
      r.span_y       = cur_y[7:0];
      r.span_len     = 9'(((end_x > 256) ? 256 : end_x) - int'(cur_x));
      r.pen          = pen;
      r.write_enable = layer_enables();
      step_results.push_back(r);
    end
    cur_x = (end_x > int'(CursorMax)) ? CursorMax : 10'(end_x);
  endfunction

  // works out the words one accepted input word causes
  function automatic void decode_word(cmd_e cmd, logic [7:0] data, logic src_end);
    res_t       r;
    logic [3:0] op;
    logic       stopped;
    step_results.delete();
    stopped = 1'b0;
    r = '0;
    case (cmd)
      CMD_START: begin
        run_active = 1'b1;
        phase      = PH_OPCODE;
        cur_x      = {2'b0, cfg_dest_x};
        cur_y      = {2'b0, cfg_dest_y};
      end
      CMD_LAYER: layer_mask = data;
      CMD_CLEAR: begin
        r.kind         = KIND_FILL;
        r.span_x       = cfg_dest_x;
        r.span_y       = cfg_dest_y;
        r.pen          = data[7:4];
        r.write_enable = layer_enables();
        r.fill_start   = {cfg_dest_y, cfg_dest_x};
        step_results.push_back(r);
      end
      default: begin
        if (run_active) begin
          case (phase)
            PH_OPCODE: begin
              op = data[3:0];
              if (op == OpStop) begin
                run_active = 1'b0;
                stopped    = 1'b1;
                r.kind     = KIND_STOP;
                step_results.push_back(r);
              end else if (op <= OpShortHi) begin
                plot_span(int'(op), data[7:4]);
              end else if (op == OpCount) begin
                pen_hold = data[7:4];
                phase    = PH_COUNT;
              end else if (op == OpMove) begin
                pen_hold = data[7:4];
                phase    = PH_COLUMN;
              end else if (op == OpLayer) begin
                cur_x = {2'b0, cfg_dest_x};
                phase = PH_LAYER;
              end else begin
                cur_y = (cur_y == CursorMax) ? CursorMax : cur_y + 10'd1;
                cur_x = {2'b0, cfg_dest_x};
              end
            end
            PH_LAYER: begin
              layer_mask = data;
              phase      = PH_OPCODE;
            end
            PH_COLUMN: begin
              cur_x = {2'b0, cfg_dest_x} + {2'b0, data};
              phase = PH_COUNT;
            end
            default: begin
              phase = PH_OPCODE;
              plot_span(int'(data), pen_hold);
            end
          endcase
          if (!stopped && src_end) begin
            run_active = 1'b0;
            phase      = PH_OPCODE;
            r          = '0;
            r.kind     = KIND_OVERRUN;
            step_results.push_back(r);
          end
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_spans.push_back(step_results[i]);
  endfunction

  task automatic send_word(cmd_e cmd, logic [7:0] data, logic src_end);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    s_axis_tlast  <= src_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_word(cmd, data, src_end);
    words_sent++;
  endtask

  // lower valid and let every outstanding word come out
  task automatic drain_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [7:0] value);
    drain_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_DEST_X: cfg_dest_x = value;
      REG_DEST_Y: cfg_dest_y = value;
      default:    cfg_present = value[3:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_config(logic [7:0] dx, logic [7:0] dy, logic [7:0] pb);
    write_reg(REG_DEST_X, dx);
    write_reg(REG_DEST_Y, dy);
    write_reg(REG_PRESENT, pb);
  endtask

  // opcode bytes in opcode phase, any byte as operand; never a stop
  function automatic logic [7:0] pick_stream_byte();
    int         w;
    logic [3:0] op;
    if (phase != PH_OPCODE) return 8'($urandom);
    w = $urandom_range(99);
    if (w < 45)      op = 4'($urandom_range(11, 1));
    else if (w < 60) op = OpCount;
    else if (w < 72) op = OpMove;
    else if (w < 80) op = OpLayer;
    else             op = OpLine;
    return {4'($urandom), op};
  endfunction

  task automatic random_stream(int n);
    int i;
    int w;
    if ($urandom_range(9) == 0) send_word(CMD_STREAM, 8'($urandom), 1'($urandom));
    send_word(CMD_START, 8'($urandom), 1'($urandom));
    for (i = 0; i < n && run_active; i++) begin
      w = $urandom_range(99);
      if (w < 4)      send_word(CMD_LAYER, 8'($urandom), 1'($urandom));
      else if (w < 7) send_word(CMD_CLEAR, 8'($urandom), 1'($urandom));
      else if (w < 8) send_word(CMD_START, 8'($urandom), 1'($urandom));
      else            send_word(CMD_STREAM, pick_stream_byte(), $urandom_range(99) == 0);
    end
    if (run_active) begin
      if (phase == PH_OPCODE && $urandom_range(1) == 1)
        send_word(CMD_STREAM, {4'($urandom), OpStop}, 1'($urandom));
      else
        send_word(CMD_STREAM, pick_stream_byte(), 1'b1);
    end
  endtask

  task automatic test_directed();
    send_word(CMD_STREAM, 8'h31, 1'b0);            // idle: ignored
    send_word(CMD_START, 8'h00, 1'b0);
    send_word(CMD_STREAM, {4'hf, 4'd1}, 1'b0);
    send_word(CMD_STREAM, {4'h0, 4'd11}, 1'b0);
    send_word(CMD_STREAM, {4'h5, OpCount}, 1'b0);
    send_word(CMD_STREAM, 8'h00, 1'b0);            // empty span
    send_word(CMD_STREAM, {4'ha, OpCount}, 1'b0);
    send_word(CMD_STREAM, 8'hff, 1'b0);            // clipped at right edge
    send_word(CMD_STREAM, {4'h7, OpMove}, 1'b0);
    send_word(CMD_STREAM, 8'h80, 1'b0);
    send_word(CMD_STREAM, 8'h01, 1'b0);
    send_word(CMD_STREAM, {4'h2, OpLayer}, 1'b0);
    send_word(CMD_STREAM, 8'ha5, 1'b0);
    send_word(CMD_STREAM, {4'h9, 4'd3}, 1'b0);
    send_word(CMD_STREAM, {4'h0, OpLine}, 1'b0);
    send_word(CMD_LAYER, 8'hff, 1'b1);             // all layers masked mid-run
    send_word(CMD_STREAM, {4'h6, 4'd2}, 1'b0);
    send_word(CMD_LAYER, 8'h00, 1'b0);
    send_word(CMD_CLEAR, 8'hf0, 1'b0);
    send_word(CMD_CLEAR, 8'h0f, 1'b1);
    send_word(CMD_STREAM, {4'h4, OpStop}, 1'b0);
    send_word(CMD_START, 8'hff, 1'b1);
    send_word(CMD_STREAM, {4'h3, OpCount}, 1'b1);  // overrun waiting for operand
    send_word(CMD_START, 8'h00, 1'b0);
    send_word(CMD_STREAM, {4'h1, OpStop}, 1'b1);   // stop on last byte: no overrun
    send_word(CMD_START, 8'h00, 1'b0);
    send_word(CMD_STREAM, {4'h4, 4'd5}, 1'b1);     // span then overrun
    send_word(CMD_START, 8'h00, 1'b0);
    send_word(CMD_STREAM, {4'hd, OpMove}, 1'b0);
    send_word(CMD_START, 8'h00, 1'b0);             // restart mid-operand
    send_word(CMD_STREAM, {4'he, OpStop}, 1'b0);
  endtask

  // a wrapping cursor would land back inside the bitmap
  task automatic test_cursor_saturation();
    int i;
    apply_config(8'hff, 8'hff, 8'h08);
    send_word(CMD_START, 8'h00, 1'b0);
    send_word(CMD_STREAM, {4'h3, OpMove}, 1'b0);
    send_word(CMD_STREAM, 8'hff, 1'b0);
    send_word(CMD_STREAM, 8'hff, 1'b0);
    send_word(CMD_STREAM, {4'h3, OpCount}, 1'b0);
    send_word(CMD_STREAM, 8'hff, 1'b0);
    send_word(CMD_STREAM, {4'h3, 4'd11}, 1'b0);
    send_word(CMD_STREAM, {4'h3, 4'd1}, 1'b0);
    for (i = 0; i < 800; i++) send_word(CMD_STREAM, {4'($urandom), OpLine}, 1'b0);
    send_word(CMD_STREAM, {4'h8, 4'd11}, 1'b0);
    send_word(CMD_STREAM, {4'h8, OpStop}, 1'b0);
  endtask

  task automatic test_config_extremes();
    logic [7:0] dx_set[6];
    logic [7:0] dy_set[6];
    logic [7:0] pb_set[6];
    int k;
    int j;
    dx_set = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd250};
    dy_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd64, 8'd3};
    pb_set = '{8'd8, 8'd1, 8'd0, 8'd15, 8'h93, 8'd9};
    for (k = 0; k < 6; k++) begin
      apply_config(dx_set[k], dy_set[k], pb_set[k]);
      send_word(CMD_CLEAR, 8'($urandom), 1'b0);
      for (j = 0; j < 4; j++) random_stream($urandom_range(20, 3));
    end
  endtask

  task automatic test_idle_modes();
    int mode;
    int target;
    int streams;
    for (mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 30 : (mode == 1) ? 88 : 0;
      recv_gap_pct = (mode == 0) ? 88 : (mode == 1) ? 30 : 0;
      target  = words_sent + 300;
      streams = 0;
      while (words_sent < target) begin
        random_stream($urandom_range(30, 2));
        streams++;
        if (streams % 8 == 0) write_reg(reg_e'(2'($urandom_range(2))), 8'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    int target;
    drain_idle();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    apply_config(8'd10, 8'd20, 8'd8);
    hold_cycles = 300;
    target = words_sent + 60;
    while (words_sent < target) random_stream($urandom_range(30, 10));
  endtask

  // receiver: random gaps plus a counted hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("unexpected word, kind", m_axis_tuser, 0);
      end else begin
        want = expected_spans.pop_front();
        check_field("kind", m_axis_tuser, want.kind);
        check_field("span_x", m_axis_tdata[7:0], want.span_x);
        check_field("span_y", m_axis_tdata[15:8], want.span_y);
        check_field("span_len", m_axis_tdata[24:16], want.span_len);
        check_field("pen", m_axis_tdata[28:25], want.pen);
        check_field("write_enable", m_axis_tdata[36:29], want.write_enable);
        check_field("fill_start", m_axis_tdata[52:37], want.fill_start);
        check_field("pad", m_axis_tdata[55:53], 0);
        check_field("last", m_axis_tlast, want.last);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_START;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_DEST_X;
    cfg_data_i    = '0;
    error_count   = 0;
    words_sent    = 0;
    send_gap_pct  = 0;
    recv_gap_pct  = 0;
    hold_cycles   = 0;
    run_active    = 1'b0;
    phase         = PH_OPCODE;
    pen_hold      = '0;
    cur_x         = '0;
    cur_y         = '0;
    layer_mask    = '0;
    cfg_dest_x    = '0;
    cfg_dest_y    = '0;
    cfg_present   = 4'd8;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_cursor_saturation();
    test_config_extremes();
    test_idle_modes();
    test_backpressure();

    drain_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/brsd_pkg.sv
rtl/blitter_rle_span_decoder.sv
test/blitter_rle_span_decoder_test.sv
